[hw/rtl/ssf_pkg.sv]
`default_nettype none

package ssf_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int POS_W      = 5;
  localparam int LEVEL_W    = 8;
  localparam int PCT_W      = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_REST = 8'd127;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd129;
  localparam logic [PCT_W-1:0]   SPAWN_PERCENT_RESET = 7'd10;

  // ceil(d/10) = floor((d+9)*205 / 2048), exact for d+9 up to well past 137
  localparam logic [8:0] DECAY_ROUND = 9'd9;
  localparam logic [7:0] DECAY_RECIP = 8'd205;
  localparam int         DECAY_SHIFT = 11;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PCT_W-1:0]  roll;
    logic [POS_W-1:0]  new_x;
    logic [POS_W-1:0]  new_y;
    logic              red_high;
    logic              green_high;
    logic              blue_high;
  } item_t;

  typedef struct packed {
    logic      emit;
    slot_rec_t pixel;
    logic      wr_en;
    slot_rec_t wr_rec;
    logic      active_next;
  } step_t;

  function automatic logic [LEVEL_W-1:0] fade(input logic [LEVEL_W-1:0] c);
    logic [LEVEL_W-1:0] d;
    logic [8:0]         n;
    logic [16:0]        p;
    logic [LEVEL_W-1:0] q;
    d = c - LEVEL_REST;
    n = {1'b0, d} + DECAY_ROUND;
    p = {8'b0, n} * {9'b0, DECAY_RECIP};
    q = {2'b00, p[16:DECAY_SHIFT]};
    if (c <= LEVEL_REST) begin
      return c;
    end
    return c - q;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ssf_ram.sv]
`default_nettype none

module ssf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ssf_step.sv]
`default_nettype none

module ssf_step (
  input  wire ssf_pkg::item_t             item,
  input  wire logic                       active,
  input  wire logic [ssf_pkg::PCT_W-1:0]  spawn_percent,
  input  wire ssf_pkg::slot_rec_t         rd_rec,
  input  wire logic                       fwd_valid,
  input  wire logic [ssf_pkg::SLOT_W-1:0] fwd_addr,
  input  wire ssf_pkg::slot_rec_t         fwd_rec,
  output ssf_pkg::step_t                  step
);

  ssf_pkg::slot_rec_t cur;
  ssf_pkg::slot_rec_t faded;
  ssf_pkg::slot_rec_t spawned;
  logic               spawn;
  logic               low;

  always_comb begin
    // memory read was issued while the previous item wrote the same slot
    cur = (fwd_valid && fwd_addr == item.slot) ? fwd_rec : rd_rec;

    faded.x = cur.x;
    faded.y = cur.y;
    faded.r = ssf_pkg::fade(cur.r);
    faded.g = ssf_pkg::fade(cur.g);
    faded.b = ssf_pkg::fade(cur.b);
    low = (faded.r < ssf_pkg::LEVEL_OFF) && (faded.g < ssf_pkg::LEVEL_OFF) &&
          (faded.b < ssf_pkg::LEVEL_OFF);

    // grid is 32 x 32, so the 5-bit position needs no reduction
    spawned.x = item.new_x;
    spawned.y = item.new_y;
    spawned.r = item.red_high   ? ssf_pkg::LEVEL_HIGH : ssf_pkg::LEVEL_REST;
    spawned.g = item.green_high ? ssf_pkg::LEVEL_HIGH : ssf_pkg::LEVEL_REST;
    spawned.b = item.blue_high  ? ssf_pkg::LEVEL_HIGH : ssf_pkg::LEVEL_REST;
    spawn = !active && (item.roll < spawn_percent);

    step.emit        = active;
    step.pixel       = cur;
    step.wr_en       = active || spawn;
    step.wr_rec      = active ? faded : spawned;
    step.active_next = active ? !low : spawn;
  end

endmodule

`default_nettype wire

[hw/rtl/sparkle_slot_fader.sv]
// Sparkle slot fader: 32 slots, each with an enable bit (flip-flops, cleared
// by reset) and a position/RGB record in a 32 x 34 RAM with registered read.
// An item is taken every cycle while input is not held off; the RAM is read on
// the accepting edge and the slot is updated and written back when the item
// advances out of the update stage, with the record just written forwarded when
// the next item visits the same slot. A pixel is loaded into the output register
// at that write-back edge. Input is held off only while a pixel is ready to
// move into a still-occupied output register. No clearing pass: records are
// only used for enabled slots, which a spawn has written.
`default_nettype none

module sparkle_slot_fader (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ssf_pkg::PCT_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ssf_pkg::SLOT_W-1:0]  slot,
  input  wire logic [ssf_pkg::PCT_W-1:0]   roll,
  input  wire logic [ssf_pkg::POS_W-1:0]   new_x,
  input  wire logic [ssf_pkg::POS_W-1:0]   new_y,
  input  wire logic                        red_high,
  input  wire logic                        green_high,
  input  wire logic                        blue_high,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ssf_pkg::POS_W-1:0]        pix_x,
  output logic [ssf_pkg::POS_W-1:0]        pix_y,
  output logic [ssf_pkg::LEVEL_W-1:0]      red,
  output logic [ssf_pkg::LEVEL_W-1:0]      green,
  output logic [ssf_pkg::LEVEL_W-1:0]      blue
);

  logic [ssf_pkg::PCT_W-1:0]      spawn_percent;
  logic [ssf_pkg::SLOT_COUNT-1:0] active;
  logic                           s1_valid;
  ssf_pkg::item_t                 s1_item;
  ssf_pkg::item_t                 in_item;
  logic                           s1_stall;
  logic                           s1_adv;
  logic                           in_fire;
  logic                           ram_we;
  logic [ssf_pkg::REC_W-1:0]      rd_data;
  ssf_pkg::slot_rec_t             rd_rec;
  logic                           fwd_valid;
  logic [ssf_pkg::SLOT_W-1:0]     fwd_addr;
  ssf_pkg::slot_rec_t             fwd_rec;
  ssf_pkg::step_t                 step;
  ssf_pkg::slot_rec_t             out_rec;

  assign cfg_ready = 1'b1;

  assign in_item.slot       = slot;
  assign in_item.roll       = roll;
  assign in_item.new_x      = new_x;
  assign in_item.new_y      = new_y;
  assign in_item.red_high   = red_high;
  assign in_item.green_high = green_high;
  assign in_item.blue_high  = blue_high;

  assign s1_stall = s1_valid && step.emit && out_valid && !out_ready;
  assign s1_adv   = s1_valid && !s1_stall;
  assign in_ready = !s1_stall;
  assign in_fire  = in_valid && in_ready;
  assign ram_we   = s1_adv && step.wr_en;
  assign rd_rec   = ssf_pkg::slot_rec_t'(rd_data);

  ssf_ram #(
    .WIDTH(ssf_pkg::REC_W),
    .DEPTH(ssf_pkg::SLOT_COUNT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(s1_item.slot),
    .wr_data(step.wr_rec),
    .rd_en  (in_fire),
    .rd_addr(slot),
    .rd_data(rd_data)
  );

  ssf_step u_step (
    .item         (s1_item),
    .active       (active[s1_item.slot]),
    .spawn_percent(spawn_percent),
    .rd_rec       (rd_rec),
    .fwd_valid    (fwd_valid),
    .fwd_addr     (fwd_addr),
    .fwd_rec      (fwd_rec),
    .step         (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spawn_percent <= ssf_pkg::SPAWN_PERCENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      spawn_percent <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid  <= in_fire;
        fwd_valid <= ram_we;
      end
      if (s1_adv) begin
        active[s1_item.slot] <= step.active_next;
      end
      if (s1_adv && step.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
    end
    if (in_ready) begin
      fwd_addr <= s1_item.slot;
      fwd_rec  <= step.wr_rec;
    end
    if (s1_adv && step.emit) begin
      out_rec <= step.pixel;
    end
  end

  assign pix_x = out_rec.x;
  assign pix_y = out_rec.y;
  assign red   = out_rec.r;
  assign green = out_rec.g;
  assign blue  = out_rec.b;

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && step.emit) |=> out_valid)
    else $error("pixel update did not reach the output register");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s1_stall |=> (s1_valid && $stable(s1_item)))
    else $error("stalled item lost or changed");

  a_write_needs_active: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (active[s1_item.slot] || step.active_next))
    else $error("record written for a slot that stays disabled");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && step.emit && out_valid && !out_ready) |-> !in_fire)
    else $error("transfer accepted while the update stage is blocked");

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  localparam int SLOT_COUNT = ssf_pkg::SLOT_COUNT;
  localparam int SLOT_W     = ssf_pkg::SLOT_W;
  localparam int POS_W      = ssf_pkg::POS_W;
  localparam int LEVEL_W    = ssf_pkg::LEVEL_W;
  localparam int PCT_W      = ssf_pkg::PCT_W;

  localparam logic [LEVEL_W-1:0] LEVEL_REST          = ssf_pkg::LEVEL_REST;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH          = ssf_pkg::LEVEL_HIGH;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF           = ssf_pkg::LEVEL_OFF;
  localparam logic [PCT_W-1:0]   SPAWN_PERCENT_RESET = ssf_pkg::SPAWN_PERCENT_RESET;

  typedef ssf_pkg::item_t item_t;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
  } sparkle_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PCT_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [SLOT_W-1:0]    slot;
  logic [PCT_W-1:0]     roll;
  logic [POS_W-1:0]     new_x;
  logic [POS_W-1:0]     new_y;
  logic                 red_high;
  logic                 green_high;
  logic                 blue_high;
  logic                 out_valid;
  logic                 out_ready;
  logic [POS_W-1:0]     pix_x;
  logic [POS_W-1:0]     pix_y;
  logic [LEVEL_W-1:0]   red;
  logic [LEVEL_W-1:0]   green;
  logic [LEVEL_W-1:0]   blue;

  // predicted slot table
  logic             slot_lit [SLOT_COUNT];
  sparkle_t         slot_mem [SLOT_COUNT];
  logic [PCT_W-1:0] spawn_pct;
  sparkle_t         pixel_q [$];

  int err_count   = 0;
  int cycle_count = 0;
  bit gap_on      = 1'b1;
  bit stall_on    = 1'b0;
  int hold_len    = 0;

  sparkle_slot_fader u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .slot       (slot),
    .roll       (roll),
    .new_x      (new_x),
    .new_y      (new_y),
    .red_high   (red_high),
    .green_high (green_high),
    .blue_high  (blue_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one step toward rest: ceil((c-127)/10), rest level and below untouched
  function automatic logic [LEVEL_W-1:0] decay_level(input logic [LEVEL_W-1:0] c);
    int d;
    if (c <= LEVEL_REST) begin
      return c;
    end
    d = int'(c) - int'(LEVEL_REST);
    return LEVEL_W'(int'(c) - (d + 9) / 10);
  endfunction

  function automatic void visit_slot(input item_t it);
    sparkle_t sp;
    if (slot_lit[it.slot]) begin
      sp = slot_mem[it.slot];
      pixel_q.push_back(sp);
      sp.r = decay_level(sp.r);
      sp.g = decay_level(sp.g);
      sp.b = decay_level(sp.b);
      slot_mem[it.slot] = sp;
      if (sp.r < LEVEL_OFF && sp.g < LEVEL_OFF && sp.b < LEVEL_OFF) begin
        slot_lit[it.slot] = 1'b0;
      end
    end else if (it.roll < spawn_pct) begin
      sp.x = it.new_x;
      sp.y = it.new_y;
      sp.r = it.red_high   ? LEVEL_HIGH : LEVEL_REST;
      sp.g = it.green_high ? LEVEL_HIGH : LEVEL_REST;
      sp.b = it.blue_high  ? LEVEL_HIGH : LEVEL_REST;
      slot_mem[it.slot] = sp;
      slot_lit[it.slot] = 1'b1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t make_visit(input int s, input int rl, input int x, input int y,
                                       input int rh, input int gh, input int bh);
    item_t it;
    it.slot       = SLOT_W'(s);
    it.roll       = PCT_W'(rl);
    it.new_x      = POS_W'(x);
    it.new_y      = POS_W'(y);
    it.red_high   = 1'(rh);
    it.green_high = 1'(gh);
    it.blue_high  = 1'(bh);
    return it;
  endfunction

  // slot_hi narrows the slot range so slots get revisited often
  function automatic item_t rand_visit(input int slot_hi);
    int rl;
    rl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 99);
    return make_visit($urandom_range(0, slot_hi), rl, $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1));
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    slot       <= it.slot;
    roll       <= it.roll;
    new_x      <= it.new_x;
    new_y      <= it.new_y;
    red_high   <= it.red_high;
    green_high <= it.green_high;
    blue_high  <= it.blue_high;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    visit_slot(it);
  endtask

  // no-spawn visits leave nothing in the queue, so give the pipe time to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spawn_pct(input int pct);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= PCT_W'(pct);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    spawn_pct = PCT_W'(pct);
    cfg_valid <= 1'b0;
  endtask

  // runs with the reset threshold of 10
  task automatic test_directed();
    send_item(make_visit(0, 0, 31, 0, 1, 1, 1));
    send_item(make_visit(1, 9, 0, 31, 0, 0, 0));
    send_item(make_visit(2, 10, 5, 5, 1, 1, 1));
    send_item(make_visit(31, 127, 31, 31, 1, 1, 1));
    send_item(make_visit(3, 5, 17, 9, 1, 0, 0));
    // all channels at rest: emits once, then the slot goes idle
    send_item(make_visit(1, 50, 2, 2, 1, 1, 1));
    send_item(make_visit(1, 99, 3, 3, 1, 1, 1));
    for (int i = 0; i < 8; i++) begin
      send_item(make_visit(0, 99, 0, 0, 0, 0, 0));
      send_item(make_visit(3, 64, 31, 31, 1, 1, 1));
    end
  endtask

  // fade a full-white sparkle until every channel drops below the off level
  task automatic test_full_fade();
    write_spawn_pct(100);
    send_item(make_visit(5, 99, $urandom_range(0, 31), $urandom_range(0, 31), 1, 1, 1));
    repeat (40) begin
      send_item(make_visit(5, 100, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1)));
    end
  endtask

  task automatic test_spawn_sweep();
    int pcts [5] = '{0, 1, 50, 101, 127};
    stall_on = 1'b1;
    foreach (pcts[i]) begin
      write_spawn_pct(pcts[i]);
      repeat (30) send_item(rand_visit((i % 2) ? 31 : 7));
    end
  endtask

  // output held off while nearly every idle slot spawns, so the block must stall its input
  task automatic test_backpressure();
    write_spawn_pct(127);
    gap_on   = 1'b0;
    stall_on = 1'b0;
    hold_len = 200;
    repeat (60) send_item(rand_visit(7));
    gap_on   = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_mix();
    write_spawn_pct(30);
    gap_on   = 1'b1;
    stall_on = 1'b1;
    repeat (100) send_item(rand_visit($urandom_range(0, 1) ? 31 : 3));
    write_spawn_pct(100);
    gap_on   = 1'b0;
    stall_on = 1'b0;
    repeat (100) send_item(rand_visit($urandom_range(0, 1) ? 31 : 3));
    write_spawn_pct(int'(SPAWN_PERCENT_RESET));
    gap_on   = 1'b0;
    stall_on = 1'b1;
    repeat (50) send_item(rand_visit($urandom_range(0, 1) ? 31 : 3));
    gap_on   = 1'b1;
    stall_on = 1'b0;
    repeat (50) send_item(rand_visit($urandom_range(0, 1) ? 31 : 3));
  endtask

  initial begin : drive_out_ready
    int  n;
    logic v;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        v        = 1'b0;
        n        = hold_len;
        hold_len = 0;
      end else if (stall_on && $urandom_range(0, 99) < 30) begin
        v = 1'b0;
        n = pick_gap() + 1;
      end else begin
        v = 1'b1;
        n = stall_on ? $urandom_range(1, 8) : 1;
      end
      out_ready <= v;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_pixels
    sparkle_t e;
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected pixel x=%0d y=%0d rgb=%0d/%0d/%0d", pix_x, pix_y,
                   red, green, blue);
        end
      end else begin
        e = pixel_q.pop_front();
        if (pix_x !== e.x || pix_y !== e.y || red !== e.r || green !== e.g ||
            blue !== e.b) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("pixel mismatch: exp %0d,%0d %0d/%0d/%0d, got %0d,%0d %0d/%0d/%0d",
                     e.x, e.y, e.r, e.g, e.b, pix_x, pix_y, red, green, blue);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** sparkle_slot_fader: FAILED **");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    slot       <= '0;
    roll       <= '0;
    new_x      <= '0;
    new_y      <= '0;
    red_high   <= 1'b0;
    green_high <= 1'b0;
    blue_high  <= 1'b0;
    spawn_pct  = SPAWN_PERCENT_RESET;
    foreach (slot_lit[i]) slot_lit[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_fade();
    test_spawn_sweep();
    test_backpressure();
    test_random_mix();

    wait_idle();
    if (err_count == 0 && pixel_q.size() == 0) begin
      $display("** sparkle_slot_fader: PASSED **");
    end else begin
      $display("** sparkle_slot_fader: FAILED **");
    end
    $finish;
  end

endmodule
